FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the range lookup block, included by ip_range_lookup_core.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/iprl_pkg.sv
// Package for the IPv4 range lookup block: table sizes, field widths,
// action codes and the record word layout. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iprl_pkg;

    // Table geometry
    localparam int PREFIX_BITS  = 16;
    localparam int PREFIX_DEPTH = 1 << PREFIX_BITS;
    localparam int RECORD_DEPTH = 65536;
    localparam int RIDX_W       = $clog2(RECORD_DEPTH);
    localparam int LIMIT_W      = RIDX_W + 1;

    // Field widths
    localparam int ACTION_W  = 2;
    localparam int INDEX_W   = 16;
    localparam int ADDR_W    = 32;
    localparam int START_W   = 16;
    localparam int OFFSET_W  = 24;
    localparam int LENGTH_W  = 16;
    localparam int COUNT_W   = 17;

    // Stream payload widths
    localparam int S_TDATA_W = INDEX_W + ADDR_W + START_W + OFFSET_W + LENGTH_W;
    localparam int M_TDATA_W = OFFSET_W + LENGTH_W;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PREFIX = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

    // One record memory word
    typedef struct packed {
        logic [ADDR_W-1:0]   range_end;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
    } record_t;

    localparam int RECORD_W = $bits(record_t);

endpackage

`default_nettype wire

FILE: rtl/iprl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module iprl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/ip_range_lookup_core.sv
// IPv4 range lookup engine: sequencer around a prefix memory and a record memory.
// Depends on iprl_pkg, iprl_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Load beats (action 0 prefix, action 1 record) write one memory entry each. A
// lookup beat (action 2) reads the prefix memory for the starting record, then
// reads the record memory one entry per cycle until the first record whose end
// address is at least the lookup address, or until the record count (capped at
// the record depth) is reached; no record is read when the start is already at
// or past that capped count. s_tready stays low from a lookup beat through its
// prefix read, its record reads and S_DONE, where the result waits while the
// output register is still full; the single read port of the record memory sets
// the one-record-per-cycle pace. The result sits in an output register, so the
// next beats are taken while it waits. Action 3 is dropped. Both memories hold
// unknown data until written; no clearing is done after reset.
// record_count must only be written while no lookup is in flight.
module ip_range_lookup_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [iprl_pkg::COUNT_W-1:0]   cfg_wdata,   // record_count
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // table_index[15:0], address[47:16], start_record[63:48],
    // data_offset[87:64], data_length[103:88]
    input  wire logic [iprl_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [iprl_pkg::ACTION_W-1:0]  s_tuser,     // action[1:0]
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // result_offset[23:0], result_length[39:24]
    output logic [iprl_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                          m_tuser      // found[0]
);

    `include "assert_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PFX  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                        state_reg, state_next;
    logic [iprl_pkg::COUNT_W-1:0]      count_reg;
    logic [iprl_pkg::LIMIT_W-1:0]      ptr_reg, ptr_next;
    logic [iprl_pkg::ADDR_W-1:0]       addr_reg, addr_next;
    logic                              found_reg, found_next;
    logic [iprl_pkg::OFFSET_W-1:0]     off_reg, off_next;
    logic [iprl_pkg::LENGTH_W-1:0]     len_reg, len_next;
    logic                              m_tvalid_reg;
    logic [iprl_pkg::M_TDATA_W-1:0]    m_tdata_reg;
    logic                              m_found_reg;

    logic                              in_fire;
    logic [iprl_pkg::INDEX_W-1:0]      in_index;
    logic [iprl_pkg::ADDR_W-1:0]       in_address;
    logic [iprl_pkg::START_W-1:0]      in_start;
    logic [iprl_pkg::OFFSET_W-1:0]     in_offset;
    logic [iprl_pkg::LENGTH_W-1:0]     in_length;
    logic                              pfx_we;
    logic                              rec_we;
    logic [iprl_pkg::PREFIX_BITS-1:0]  pfx_waddr;
    logic [iprl_pkg::PREFIX_BITS-1:0]  pfx_raddr;
    logic [iprl_pkg::START_W-1:0]      pfx_rdata;
    logic [iprl_pkg::RIDX_W-1:0]       rec_waddr;
    logic [iprl_pkg::RIDX_W-1:0]       rec_raddr;
    iprl_pkg::record_t                 rec_wdata;
    iprl_pkg::record_t                 rec_rdata;
    logic [iprl_pkg::LIMIT_W-1:0]      scan_limit;
    logic [iprl_pkg::LIMIT_W-1:0]      ptr_inc;
    logic                              out_load;

    // Unpack the input beat
    assign in_index   = s_tdata[15:0];
    assign in_address = s_tdata[47:16];
    assign in_start   = s_tdata[63:48];
    assign in_offset  = s_tdata[87:64];
    assign in_length  = s_tdata[103:88];

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // Table write ports, out-of-range indexes dropped
    always_comb
    begin
        pfx_we    = in_fire && (s_tuser == iprl_pkg::ACT_PREFIX)
                    && (32'(in_index) < 32'(iprl_pkg::PREFIX_DEPTH));
        rec_we    = in_fire && (s_tuser == iprl_pkg::ACT_RECORD)
                    && (32'(in_index) < 32'(iprl_pkg::RECORD_DEPTH));
        pfx_waddr = iprl_pkg::PREFIX_BITS'(32'(in_index));
        rec_waddr = iprl_pkg::RIDX_W'(32'(in_index));
        rec_wdata.range_end = in_address;
        rec_wdata.offset    = in_offset;
        rec_wdata.length    = in_length;
        pfx_raddr = in_address[iprl_pkg::ADDR_W-1 -: iprl_pkg::PREFIX_BITS];
    end

    // Scan limit: record count capped at the record depth
    always_comb
    begin
        if (32'(count_reg) > 32'(iprl_pkg::RECORD_DEPTH))
        begin
            scan_limit = iprl_pkg::LIMIT_W'(iprl_pkg::RECORD_DEPTH);
        end
        else
        begin
            scan_limit = iprl_pkg::LIMIT_W'(32'(count_reg));
        end
    end

    // Lookup sequencer
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        addr_next  = addr_reg;
        found_next = found_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        rec_raddr  = ptr_reg[iprl_pkg::RIDX_W-1:0];
        ptr_inc    = ptr_reg + iprl_pkg::LIMIT_W'(1);
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (s_tuser == iprl_pkg::ACT_LOOKUP))
                begin
                    addr_next  = in_address;
                    state_next = S_PFX;
                end
            end
            S_PFX:
            begin
                // prefix entry is on the read port now
                if (32'(pfx_rdata) >= 32'(scan_limit))
                begin
                    found_next = 1'b0;
                    off_next   = '0;
                    len_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = iprl_pkg::LIMIT_W'(32'(pfx_rdata));
                    rec_raddr  = iprl_pkg::RIDX_W'(32'(pfx_rdata));
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // record ptr_reg is on the read port now
                if (rec_rdata.range_end >= addr_reg)
                begin
                    if (rec_rdata.offset != '0)
                    begin
                        found_next = 1'b1;
                        off_next   = rec_rdata.offset;
                        len_next   = rec_rdata.length;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        off_next   = '0;
                        len_next   = '0;
                    end
                    state_next = S_DONE;
                end
                else if (ptr_inc >= scan_limit)
                begin
                    found_next = 1'b0;
                    off_next   = '0;
                    len_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next  = ptr_inc;
                    rec_raddr = ptr_inc[iprl_pkg::RIDX_W-1:0];
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        addr_reg  <= addr_next;
        found_reg <= found_next;
        off_reg   <= off_next;
        len_reg   <= len_next;
        if (out_load)
        begin
            m_tdata_reg <= {len_reg, off_reg};
            m_found_reg <= found_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_found_reg;

    // Prefix memory: starting record per prefix
    iprl_ram #(
        .WIDTH (iprl_pkg::START_W),
        .DEPTH (iprl_pkg::PREFIX_DEPTH)
    ) u_prefix_ram (
        .clk   (clk),
        .we    (pfx_we),
        .waddr (pfx_waddr),
        .wdata (in_start),
        .raddr (pfx_raddr),
        .rdata (pfx_rdata)
    );

    // Record memory: end address, offset and length per record
    iprl_ram #(
        .WIDTH (iprl_pkg::RECORD_W),
        .DEPTH (iprl_pkg::RECORD_DEPTH)
    ) u_record_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    // Checks
    `ASSERT_CLK(a_scan_in_limit, (state_reg == S_SCAN) |-> (ptr_reg < scan_limit),
        "scan pointer at or past the record limit")
    `ASSERT_CLK(a_lookup_starts,
        (in_fire && (s_tuser == iprl_pkg::ACT_LOOKUP)) |=> (state_reg == S_PFX),
        "lookup beat did not start a prefix read")
    `ASSERT_NEVER(a_found_zero_off, m_tvalid && m_tuser[0] && (m_tdata[23:0] == '0),
        "found result with zero offset")
    `ASSERT_NEVER(a_miss_nonzero, m_tvalid && !m_tuser[0] && (m_tdata != '0),
        "not-found result with nonzero payload")
    `ASSERT_NEVER(a_write_in_scan, (state_reg != S_IDLE) && (pfx_we || rec_we),
        "table write while a lookup is in flight")

endmodule

`default_nettype wire
